FILE: hw/rtl/lspq_pkg.sv
// ----------------------------------------------------------------------------
// lspq_pkg
// Shared types and codes of the linear-scan priority queue: entry layout,
// result status codes, item kinds and the scan compare control bundle.
// ----------------------------------------------------------------------------
package lspq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int OCC_W    = 9;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    // result status codes
    localparam t_status ST_ENQUEUED = 2'd0;
    localparam t_status ST_DEQUEUED = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

    // item kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // order mode: 1 takes highest priority first
    localparam logic MODE_LOWEST  = 1'b0;
    localparam logic MODE_HIGHEST = 1'b1;
    localparam logic MODE_RESET   = MODE_HIGHEST;

    // one stored table entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // control that goes with each read beat into the select unit
    typedef struct packed {
        logic valid;    // read data of a scanned entry arrives this cycle
        logic first;    // first entry of the scan, taken unconditionally
        logic highest;  // order mode
    } t_cmp_ctl;

endpackage

FILE: hw/rtl/lspq_ram.sv
// ----------------------------------------------------------------------------
// lspq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module lspq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/lspq_select.sv
// ----------------------------------------------------------------------------
// lspq_select
// Running best-entry tracker for the scan: compares each read beat with the
// current pick and keeps the winner and its table index.
// ----------------------------------------------------------------------------
module lspq_select #(
    parameter int ADDR_W = 8
) (
    input  logic                i_clk,
    input  lspq_pkg::t_cmp_ctl  i_ctl,
    input  logic [ADDR_W-1:0]   i_idx,
    input  lspq_pkg::t_entry    i_data,
    output lspq_pkg::t_entry    o_best,
    output logic [ADDR_W-1:0]   o_best_idx
);

    import lspq_pkg::*;

    t_entry            r_best;
    logic [ADDR_W-1:0] r_best_idx;
    logic              w_better;
    logic              w_take;

    // priority decides per mode; equal priority goes to the larger value
    always_comb begin
        if ($signed(i_data.prio) != $signed(r_best.prio)) begin
            w_better = i_ctl.highest ? ($signed(i_data.prio) > $signed(r_best.prio))
                                     : ($signed(i_data.prio) < $signed(r_best.prio));
        end else begin
            w_better = $signed(i_data.value) > $signed(r_best.value);
        end
    end

    assign w_take = i_ctl.valid && (i_ctl.first || w_better);

    // hold the pick
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best     <= i_data;
            r_best_idx <= i_idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

FILE: hw/rtl/linear_scan_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_unit
// Enqueue: from accept straight to FINISH, then the next beat is taken.
// Dequeue: SCAN, FETCH, MOVE, FINISH, one table entry read per cycle through the
// single read port of the entry RAM; an empty dequeue goes straight to FINISH.
// One item in flight; the result register frees the input side while a
// result waits. Reset clears count, mode (highest) and handshakes; the RAM
// is not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module linear_scan_priority_queue_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic signed [lspq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic signed [lspq_pkg::PRIO_W-1:0]   i_item_priority,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lspq_pkg::t_status                    o_status,
    output logic signed [lspq_pkg::VALUE_W-1:0]  o_out_value,
    output logic signed [lspq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [lspq_pkg::OCC_W-1:0]           o_occupancy
);

    import lspq_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // occupancy is the count cut to the port width
    function automatic logic [OCC_W-1:0] f_occ(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] ext;
        ext = {{OCC_W{1'b0}}, cnt};
        return ext[OCC_W-1:0];
    endfunction

    logic [2:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_mode;
    logic [ADDR_W-1:0]   r_scan, n_scan;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_cmp_first, n_cmp_first;
    logic [ADDR_W-1:0]   r_cmp_idx, n_cmp_idx;

    // pending result
    t_status             r_res_status, n_res_status;
    t_entry              r_res_entry, n_res_entry;
    logic [OCC_W-1:0]    r_res_occ, n_res_occ;

    // output register
    logic                r_out_valid;
    t_status             r_o_status;
    t_entry              r_o_entry;
    logic [OCC_W-1:0]    r_o_occ;

    logic                w_in_acc;
    logic                w_out_free;
    logic [CNT_W-1:0]    w_cnt_m1;
    logic [ADDR_W-1:0]   w_last;
    logic                w_full;

    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    t_entry              w_wr_data;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_addr;
    t_entry              w_rd_data;
    t_cmp_ctl            w_cmp_ctl;
    t_entry              w_best;
    logic [ADDR_W-1:0]   w_best_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cnt_m1   = r_count - CNT_W'(1);
    assign w_last     = w_cnt_m1[ADDR_W-1:0];
    assign w_full     = (r_count == CNT_W'(CAPACITY));

    // entry table
    lspq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // best pick over the scan beats
    assign w_cmp_ctl = '{valid: r_cmp_vld, first: r_cmp_first, highest: r_mode};

    lspq_select #(
        .ADDR_W (ADDR_W)
    ) u_select (
        .i_clk      (i_clk),
        .i_ctl      (w_cmp_ctl),
        .i_idx      (r_cmp_idx),
        .i_data     (w_rd_data),
        .o_best     (w_best),
        .o_best_idx (w_best_idx)
    );

    // sequencer: append on enqueue; on dequeue scan, then move the last
    // entry into the picked slot (table order does not affect results)
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_cmp_vld    = 1'b0;
        n_cmp_first  = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_res_occ    = r_res_occ;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_count[ADDR_W-1:0];
        w_wr_data    = '{value: i_item_value, prio: i_item_priority};
        w_rd_en      = 1'b0;
        w_rd_addr    = r_scan;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_entry = '0;
                    if (i_kind == KIND_ENQ) begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                            n_res_occ    = f_occ(r_count);
                        end else begin
                            w_wr_en      = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = ST_ENQUEUED;
                            n_res_occ    = f_occ(n_count);
                        end
                        n_state = S_FINISH;
                    end else if (r_count == '0) begin
                        n_res_status = ST_EMPTY;
                        n_res_occ    = '0;
                        n_state      = S_FINISH;
                    end else begin
                        n_scan  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_rd_en     = 1'b1;
                n_cmp_vld   = 1'b1;
                n_cmp_first = (r_scan == '0);
                n_cmp_idx   = r_scan;
                if (r_scan == w_last) begin
                    n_state = S_FETCH;
                end else begin
                    n_scan = r_scan + ADDR_W'(1);
                end
            end
            S_FETCH: begin
                // last compare runs now; fetch the tail entry
                w_rd_en   = 1'b1;
                w_rd_addr = w_last;
                n_state   = S_MOVE;
            end
            S_MOVE: begin
                w_wr_en      = 1'b1;
                w_wr_addr    = w_best_idx;
                w_wr_data    = w_rd_data;
                n_count      = w_cnt_m1;
                n_res_status = ST_DEQUEUED;
                n_res_entry  = w_best;
                n_res_occ    = f_occ(w_cnt_m1);
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_mode    <= MODE_RESET;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_scan       <= n_scan;
        r_cmp_first  <= n_cmp_first;
        r_cmp_idx    <= n_cmp_idx;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_res_occ    <= n_res_occ;
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_entry  <= r_res_entry;
            r_o_occ    <= r_res_occ;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_out_value    = r_o_entry.value;
    assign o_out_priority = r_o_entry.prio;
    assign o_occupancy    = r_o_occ;

endmodule

FILE: hw/rtl/lspq_checker.sv
// ----------------------------------------------------------------------------
// lspq_checker
// Port-level checks of the priority queue: one item in flight, result
// fields consistent with their status, and a held output beat.
// ----------------------------------------------------------------------------
module lspq_checker #(
    parameter int CAPACITY = 256
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input lspq_pkg::t_status                    o_status,
    input logic signed [lspq_pkg::VALUE_W-1:0]  o_out_value,
    input logic signed [lspq_pkg::PRIO_W-1:0]   o_out_priority,
    input logic [lspq_pkg::OCC_W-1:0]           o_occupancy
);

    import lspq_pkg::*;

    localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

    // an accepted beat is followed by a stalled input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item was in flight");

    // only a dequeued beat carries a removed pair
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_DEQUEUED)
            |-> (o_out_value == '0 && o_out_priority == '0))
        else $error("payload not zero on a non-dequeue result");

    // empty reports no entries, full reports the capacity
    a_occ_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status != ST_EMPTY || o_occupancy == '0)
                      && (o_status != ST_FULL || o_occupancy == CAP_OCC)))
        else $error("occupancy does not match status");

    // a stalled output beat keeps its valid, status, value and occupancy
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_out_value) && $stable(o_occupancy)))
        else $error("stalled output beat changed");

endmodule

bind linear_scan_priority_queue_unit lspq_checker #(
    .CAPACITY (CAPACITY)
) u_lspq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_out_value    (o_out_value),
    .o_out_priority (o_out_priority),
    .o_occupancy    (o_occupancy)
);

FILE: tb/lspq_result_checker.sv
// ----------------------------------------------------------------------------
// lspq_result_checker
// Watches both channels and the mode register of the linear-scan priority
// queue. It keeps its own copy of the entry table, works out the result of
// every accepted input beat, and compares each accepted output beat field by
// field with the oldest result still due. Mismatch and pending counts go to
// the testbench top.
// ----------------------------------------------------------------------------
module lspq_result_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic                                 i_cfg_wr_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic                                 i_kind,
    input  logic signed [lspq_pkg::VALUE_W-1:0]  i_item_value,
    input  logic signed [lspq_pkg::PRIO_W-1:0]   i_item_priority,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  lspq_pkg::t_status                    i_status,
    input  logic signed [lspq_pkg::VALUE_W-1:0]  i_out_value,
    input  logic signed [lspq_pkg::PRIO_W-1:0]   i_out_priority,
    input  logic [lspq_pkg::OCC_W-1:0]           i_occupancy,
    output int                                   o_error_count,
    output int                                   o_pending_count
);

    import lspq_pkg::*;

    // one result beat as the block should return it
    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [OCC_W-1:0]          occ;
    } t_reply;

    // shadow of the entry table, kept in arrival order
    logic signed [VALUE_W-1:0] held_value [CAPACITY];
    logic signed [PRIO_W-1:0]  held_prio  [CAPACITY];
    int                        held_count;
    logic                      mode;

    t_reply due_replies [$];
    int     errors = 0;

    // true when entry c beats the current pick b
    function automatic bit outranks(input int c, input int b);
        if (held_prio[c] != held_prio[b])
            return (mode == MODE_HIGHEST) ? (held_prio[c] > held_prio[b])
                                          : (held_prio[c] < held_prio[b]);
        // equal priority: larger value wins, earliest on a full tie
        return held_value[c] > held_value[b];
    endfunction

    // apply one input beat to the shadow table and return its result
    function automatic t_reply serve_item(input logic k,
                                          input logic signed [VALUE_W-1:0] v,
                                          input logic signed [PRIO_W-1:0] p);
        t_reply r;
        int     pick;
        r.status = ST_ENQUEUED;
        r.value  = '0;
        r.prio   = '0;
        if (k == KIND_ENQ) begin
            if (held_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                held_value[held_count] = v;
                held_prio[held_count]  = p;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            pick = 0;
            for (int i = 1; i < held_count; i++)
                if (outranks(i, pick))
                    pick = i;
            r.status = ST_DEQUEUED;
            r.value  = held_value[pick];
            r.prio   = held_prio[pick];
            // close the gap, keeping order
            for (int i = pick; i + 1 < held_count; i++) begin
                held_value[i] = held_value[i+1];
                held_prio[i]  = held_prio[i+1];
            end
            held_count--;
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    // track config, predict on input beats, compare on output beats
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            held_count = 0;
            mode       = MODE_RESET;
            due_replies.delete();
        end else begin
            if (i_cfg_wr_en)
                mode = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                due_replies.push_back(serve_item(i_kind, i_item_value, i_item_priority));
            if (i_out_valid && !i_out_stall) begin
                if (due_replies.size() == 0) begin
                    $error("result beat with nothing due: status %0d occupancy %0d",
                           i_status, i_occupancy);
                    errors++;
                end else begin
                    want = due_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        errors++;
                    end
                    if (i_out_value !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value, i_out_value);
                        errors++;
                    end
                    if (i_out_priority !== want.prio) begin
                        $error("out_priority: expected %0d, got %0d",
                               want.prio, i_out_priority);
                        errors++;
                    end
                    if (i_occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, i_occupancy);
                        errors++;
                    end
                end
            end
        end
        o_error_count   <= errors;
        o_pending_count <= due_replies.size();
    end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the linear-scan priority queue. Drives a directed run
// over the field extremes, ties and the empty case, then random
// phases of fills, drains and mixed traffic under both order modes, with
// random gaps on both channels and one long output hold-off. Checking is
// done by the result checker; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb;

    import lspq_pkg::*;

    localparam int CAPACITY     = 256;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES  = 400;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_PRESSURE} t_phase;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic                      cfg_wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic                      kind;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRIO_W-1:0]  item_priority;
    logic                      out_valid;
    logic                      out_stall;
    t_status                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic signed [PRIO_W-1:0]  out_priority;
    logic [OCC_W-1:0]          occupancy;

    int error_count;
    int pending_count;
    int level = 0;       // rough fill level, only to size phases
    int sent = 0;        // random beats offered so far
    bit burst = 1'b0;    // no idling on either side
    int hold_asks = 0;

    linear_scan_priority_queue_unit #(.CAPACITY(CAPACITY)) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (kind),
        .i_item_value   (item_value),
        .i_item_priority(item_priority),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_out_value    (out_value),
        .o_out_priority (out_priority),
        .o_occupancy    (occupancy)
    );

    lspq_result_checker #(.CAPACITY(CAPACITY)) u_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_kind         (kind),
        .i_item_value   (item_value),
        .i_item_priority(item_priority),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_out_value    (out_value),
        .i_out_priority (out_priority),
        .i_occupancy    (occupancy),
        .o_error_count  (error_count),
        .o_pending_count(pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest correct run
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stall after each beat, plus the long hold-off
    initial begin : receiver
        int n;
        int hold_done;
        hold_done = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asks != hold_done) begin
                hold_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if (out_valid && !out_stall) begin
                n = burst ? 0 : $urandom_range(0, 9);
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // offer one beat after a random gap and wait until it is taken;
    // valid stays high when the next beat follows with no gap
    task automatic send_item(input logic k,
                             input logic signed [VALUE_W-1:0] v,
                             input logic signed [PRIO_W-1:0] p);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        item_value    <= v;
        item_priority <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (k == KIND_ENQ) begin
            if (level < CAPACITY) level++;
        end else if (level > 0) begin
            level--;
        end
    endtask

    // random content, biased toward ties and extremes
    task automatic offer_random(input logic k);
        logic signed [VALUE_W-1:0] v;
        logic signed [PRIO_W-1:0]  p;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom_range(0, 6);
                v = v - 3;
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: p = 16'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: p = 16'sh7FFF;
                    1: p = 16'sh8000;
                    2: p = '0;
                    default: p = '1;
                endcase
            end
            2: p = 16'($urandom_range(0, 7));
            default: begin
                p = 16'($urandom_range(0, 4));
                p = p - 16'sd2;
            end
        endcase
        send_item(k, v, p);
        sent++;
    endtask

    // drop valid and wait until every due result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        t_phase shape;
        logic   m;
        int     n;
        int     bias;
        int     ph;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= KIND_ENQ;
        item_value    <= '0;
        item_priority <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset mode is highest first
        send_item(KIND_DEQ, 32'sh5A5A_A5A5, 16'shFFFF);  // empty, junk fields
        send_item(KIND_ENQ, 32'sh7FFF_FFFF, 16'sh0000);
        send_item(KIND_ENQ, 32'sh8000_0000, 16'sh0000);  // tie on priority
        send_item(KIND_ENQ, 32'sh0000_0000, 16'sh7FFF);
        send_item(KIND_ENQ, 32'shFFFF_FFFF, 16'sh8000);
        send_item(KIND_ENQ, 32'sd5, 16'sd7);
        send_item(KIND_ENQ, 32'sd5, 16'sd7);             // full duplicate
        send_item(KIND_ENQ, 32'sd9, 16'sd7);
        send_item(KIND_DEQ, 32'sh8000_0000, 16'sh7FFF);
        send_item(KIND_DEQ, 32'sh7FFF_FFFF, 16'sh8000);
        send_item(KIND_DEQ, '0, '0);
        send_item(KIND_DEQ, '1, '1);

        set_mode(MODE_LOWEST);
        send_item(KIND_ENQ, 32'sd100, 16'sh8000);        // ties the -1 entry
        send_item(KIND_DEQ, '0, '0);
        send_item(KIND_DEQ, '0, '0);
        send_item(KIND_DEQ, '0, '0);
        send_item(KIND_DEQ, '0, '0);
        send_item(KIND_DEQ, 32'sd1, 16'sd1);             // empty again

        // random phases
        ph = 0;
        while (sent < RANDOM_ITEMS) begin
            if (ph == 0)
                m = MODE_LOWEST;
            else if (ph == 1)
                m = MODE_HIGHEST;
            else
                m = 1'($urandom_range(0, 1));
            set_mode(m);
            burst = ($urandom_range(0, 3) == 0);

            if (ph == 0)
                shape = PH_FILL;
            else if (ph == 1)
                shape = PH_DRAIN;
            else if (ph == 2)
                shape = PH_PRESSURE;
            else begin
                case ($urandom_range(0, 5))
                    0: shape = PH_FILL;
                    1: shape = PH_DRAIN;
                    default: shape = PH_MIXED;
                endcase
            end

            case (shape)
                PH_FILL: begin
                    // run past capacity to hit the full case
                    n = CAPACITY - level + $urandom_range(1, 4);
                    repeat (n) offer_random(KIND_ENQ);
                end
                PH_DRAIN: begin
                    n = level + $urandom_range(1, 3);
                    repeat (n) offer_random(KIND_DEQ);
                end
                PH_PRESSURE: begin
                    // receiver holds off while beats keep coming
                    hold_asks++;
                    burst = 1'b1;
                    repeat (16) offer_random(1'($urandom_range(0, 1)));
                end
                default: begin
                    n    = $urandom_range(30, 120);
                    bias = $urandom_range(30, 70);
                    repeat (n)
                        offer_random(($urandom_range(0, 99) < bias) ? KIND_ENQ : KIND_DEQ);
                end
            endcase
            ph++;
        end

        settle();
        burst = 1'b0;
        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/lspq_pkg.sv
hw/rtl/lspq_ram.sv
hw/rtl/lspq_select.sv
hw/rtl/linear_scan_priority_queue_unit.sv
hw/rtl/lspq_checker.sv
tb/lspq_result_checker.sv
tb/tb.sv
